FILE: hw/rtl/kspool_pkg.sv
// Shared types and constants of the keyed slot pool.
`default_nettype none

package kspool_pkg;

  // Default sizes
  localparam int DEF_SLOTS    = 16;
  localparam int DEF_KEY_BITS = 64;

  // Fixed field widths
  localparam int STAMP_W    = 64;
  localparam int USES_W     = 32;
  localparam int IDX_OUT_W  = 4;
  localparam int CNT_OUT_W  = 5;
  localparam int TIMEOUT_W  = 31;
  localparam int WARM_W     = 5;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 56;

  localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT = 31'd60000;

  // Slot states
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_INUSE = 2'd1,
    ST_WARM  = 2'd2
  } slot_state_e;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REAP    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // Register indexes (paddr bit 2)
  localparam logic REG_TIMEOUT    = 1'b0;
  localparam logic REG_WARM_FLOOR = 1'b1;

  // Verdict of the shared slot evaluator
  typedef struct packed {
    logic              key_hit;
    logic              expired;
    logic [USES_W-1:0] uses_inc;
  } eval_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kspool_slot_mem.sv
// Slot record memory: one write port, one registered read port.
`default_nettype none

module kspool_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read one record a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/kspool_eval.sv
// Shared slot evaluator: key match, idle timeout compare and use count bump.
`default_nettype none

module kspool_eval import kspool_pkg::*; #(
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  wire logic [KEY_BITS-1:0]  rec_key_i,
  input  wire slot_state_e          rec_state_i,
  input  wire logic [STAMP_W-1:0]   rec_stamp_i,
  input  wire logic [USES_W-1:0]    rec_uses_i,
  input  wire logic [KEY_BITS-1:0]  lookup_key_i,
  input  wire logic [STAMP_W-1:0]   now_time_i,
  input  wire logic [TIMEOUT_W-1:0] idle_timeout_i,
  output eval_t                     eval_o
);

  logic [TIMEOUT_W-1:0] limit;
  logic [STAMP_W-1:0]   idle_time;

  // Zero timeout falls back to the default
  assign limit     = (idle_timeout_i == '0) ? DEFAULT_TIMEOUT : idle_timeout_i;
  // Idle time wraps modulo 2^64
  assign idle_time = now_time_i - rec_stamp_i;

  always_comb begin
    eval_o.key_hit  = (rec_state_i != ST_INUSE) && (rec_key_i == lookup_key_i);
    eval_o.expired  = (rec_state_i == ST_FREE) && (idle_time > STAMP_W'(limit));
    // Saturate at all ones
    eval_o.uses_inc = (&rec_uses_i) ? rec_uses_i : rec_uses_i + USES_W'(1);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_slot_pool_with_idle_reaping.sv
// Keyed slot pool with idle reaping: stream ports, register port and sequencer.
//
// Usage: one command word enters on the s_axis channel (tuser carries the
// operation: acquire, release, reap or no operation) and exactly one result
// word leaves on the m_axis channel. The user must write idle_timeout
// (address 0) and the warm floor (address 4) over the APB port only while
// idle; the block itself does not enforce it. Slot records live in a
// single-port-read memory; one sequencer walks it one slot per read and
// decides each slot with a shared evaluator. Each slot visit is a READ state,
// which waits for the registered memory read, and an EXAM state that decides
// the slot. No operation and a bad release go straight to the result; a
// release visits its one slot; an acquire visits slots in order until a hit;
// an acquire that appends or fails and a reap visit every entry, then close
// in a last READ. The next word is taken in the cycle after the result loads.
// s_axis_tready is high only while the sequencer is idle; it may be high
// while an earlier result still waits in the output register. A stalled
// receiver holds the result, and a finished item then waits for it.
// Reset empties the table and restores the register defaults; no memory
// clearing pass is needed since the fill count guards every read.
`default_nettype none

module keyed_slot_pool_with_idle_reaping import kspool_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int KEY_BITS = DEF_KEY_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // lookup_key[63:0], slot_index[67:64], now_time[131:68], zeros
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [OP_W-1:0]       s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // failed[0], granted_slot[4:1], slot_uses[36:5], reaped_count[41:37],
  // inuse_count[46:42], entry_count[51:47], zeros
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;
  localparam int WCMP_W  = (CNT_W > WARM_W) ? CNT_W : WARM_W;
  localparam int REC_W   = KEY_BITS + 2 + STAMP_W + USES_W;
  // Record layout from the lowest bit: uses, stamp, state, key
  localparam int STAMP_LO = USES_W;
  localparam int STATE_LO = USES_W + STAMP_W;
  localparam int KEY_LO   = USES_W + STAMP_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXAM,
    S_DONE
  } fsm_e;

  // Configuration registers
  logic [TIMEOUT_W-1:0] idle_timeout_q;
  logic [WARM_W-1:0]    warm_floor_q;

  // Sequencer state
  fsm_e                 state_q;
  op_e                  op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [STAMP_W-1:0]   now_q;
  logic [CNT_W-1:0]     ptr_q;
  logic [CNT_W-1:0]     wptr_q;
  logic [CNT_W-1:0]     fill_q;
  logic [CNT_W-1:0]     inuse_q;
  logic [CNT_W-1:0]     warm_q;
  logic [CNT_W-1:0]     reaped_q;
  logic                 res_failed_q;
  logic [IDX_OUT_W-1:0] res_granted_q;
  logic [USES_W-1:0]    res_uses_q;
  logic                 m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  // Input word fields
  logic [KEY_BITS-1:0]  in_key;
  logic [IDX_OUT_W-1:0] in_idx;
  logic [STAMP_W-1:0]   in_now;
  op_e                  in_op;
  logic                 in_accept;
  logic                 bad_release;

  // Memory ports and record fields
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [REC_W-1:0]     mem_wdata;
  logic [REC_W-1:0]     mem_rdata;
  logic [KEY_BITS-1:0]  r_key;
  slot_state_e          r_state;
  logic [STAMP_W-1:0]   r_stamp;
  logic [USES_W-1:0]    r_uses;
  eval_t                verdict;
  logic                 warm_enough;
  logic                 scan_end;
  logic                 table_full;

  // Unpack the input word
  assign in_key      = s_axis_tdata[KEY_BITS-1:0];
  assign in_idx      = s_axis_tdata[67:64];
  assign in_now      = s_axis_tdata[131:68];
  assign in_op       = op_e'(s_axis_tuser);
  assign in_accept   = s_axis_tvalid && s_axis_tready;
  assign bad_release = !(CMP_W'(in_idx) < CMP_W'(fill_q));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WARM_FLOOR) ? {{(32-WARM_W){1'b0}}, warm_floor_q}
                                               : {{(32-TIMEOUT_W){1'b0}}, idle_timeout_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= DEFAULT_TIMEOUT;
      warm_floor_q   <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WARM_FLOOR) begin
        warm_floor_q <= pwdata[WARM_W-1:0];
      end else begin
        idle_timeout_q <= pwdata[TIMEOUT_W-1:0];
      end
    end
  end

  // Record storage
  kspool_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (REC_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  assign r_uses  = mem_rdata[USES_W-1:0];
  assign r_stamp = mem_rdata[STATE_LO-1:STAMP_LO];
  assign r_state = slot_state_e'(mem_rdata[KEY_LO-1:STATE_LO]);
  assign r_key   = mem_rdata[REC_W-1:KEY_LO];

  // Shared evaluator
  kspool_eval #(
    .KEY_BITS (KEY_BITS)
  ) u_eval (
    .rec_key_i      (r_key),
    .rec_state_i    (r_state),
    .rec_stamp_i    (r_stamp),
    .rec_uses_i     (r_uses),
    .lookup_key_i   (key_q),
    .now_time_i     (now_q),
    .idle_timeout_i (idle_timeout_q),
    .eval_o         (verdict)
  );

  assign warm_enough = (WCMP_W'(warm_q) >= WCMP_W'(warm_floor_q));
  assign scan_end    = (ptr_q == fill_q);
  assign table_full  = (fill_q == CNT_W'(SLOTS));

  // Record writes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q[IDX_W-1:0];
    mem_wdata = mem_rdata;
    unique case (state_q)
      S_READ: begin
        // Append a new slot when the acquire scan found no match
        if (scan_end && op_q == OP_ACQUIRE && !table_full) begin
          mem_we    = 1'b1;
          mem_waddr = fill_q[IDX_W-1:0];
          mem_wdata = {key_q, ST_INUSE, {STAMP_W{1'b0}}, USES_W'(1)};
        end
      end
      S_EXAM: begin
        case (op_q)
          OP_ACQUIRE: begin
            if (verdict.key_hit) begin
              mem_we    = 1'b1;
              mem_wdata = {r_key, ST_INUSE, r_stamp, verdict.uses_inc};
            end
          end
          OP_RELEASE: begin
            mem_we    = 1'b1;
            mem_wdata = {r_key, ST_FREE, now_q, r_uses};
          end
          OP_REAP: begin
            // Compact kept slots down to the write pointer
            if (!(verdict.expired && warm_enough)) begin
              mem_we    = 1'b1;
              mem_waddr = wptr_q[IDX_W-1:0];
              mem_wdata = {r_key, (verdict.expired ? ST_WARM : r_state), r_stamp, r_uses};
            end
          end
          default: begin
            mem_we = 1'b0;
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      op_q          <= OP_NOP;
      key_q         <= '0;
      now_q         <= '0;
      ptr_q         <= '0;
      wptr_q        <= '0;
      fill_q        <= '0;
      inuse_q       <= '0;
      warm_q        <= '0;
      reaped_q      <= '0;
      res_failed_q  <= 1'b0;
      res_granted_q <= '0;
      res_uses_q    <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
    end else begin
      // Drop the result once taken, unless a new one loads in its place
      if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            op_q          <= in_op;
            key_q         <= in_key;
            now_q         <= in_now;
            ptr_q         <= '0;
            wptr_q        <= '0;
            reaped_q      <= '0;
            res_failed_q  <= 1'b0;
            res_granted_q <= '0;
            res_uses_q    <= '0;
            unique case (in_op)
              OP_ACQUIRE, OP_REAP: begin
                state_q <= S_READ;
              end
              OP_RELEASE: begin
                if (bad_release) begin
                  res_failed_q <= 1'b1;
                  state_q      <= S_DONE;
                end else begin
                  ptr_q   <= CNT_W'(in_idx);
                  state_q <= S_READ;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          if (scan_end) begin
            // Walk finished: append, fail or close the compaction
            if (op_q == OP_ACQUIRE) begin
              if (table_full) begin
                res_failed_q <= 1'b1;
              end else begin
                res_granted_q <= IDX_OUT_W'(fill_q);
                res_uses_q    <= USES_W'(1);
                fill_q        <= fill_q + CNT_W'(1);
                inuse_q       <= inuse_q + CNT_W'(1);
              end
            end else if (op_q == OP_REAP) begin
              fill_q <= wptr_q;
            end
            state_q <= S_DONE;
          end else begin
            state_q <= S_EXAM;
          end
        end
        S_EXAM: begin
          case (op_q)
            OP_ACQUIRE: begin
              if (verdict.key_hit) begin
                res_granted_q <= IDX_OUT_W'(ptr_q);
                res_uses_q    <= verdict.uses_inc;
                inuse_q       <= inuse_q + CNT_W'(1);
                if (r_state == ST_WARM) begin
                  warm_q <= warm_q - CNT_W'(1);
                end
                state_q <= S_DONE;
              end else begin
                ptr_q   <= ptr_q + CNT_W'(1);
                state_q <= S_READ;
              end
            end
            OP_RELEASE: begin
              if (r_state == ST_INUSE) begin
                inuse_q <= inuse_q - CNT_W'(1);
              end
              if (r_state == ST_WARM) begin
                warm_q <= warm_q - CNT_W'(1);
              end
              state_q <= S_DONE;
            end
            OP_REAP: begin
              if (verdict.expired && warm_enough) begin
                reaped_q <= reaped_q + CNT_W'(1);
              end else begin
                if (verdict.expired) begin
                  warm_q <= warm_q + CNT_W'(1);
                end
                wptr_q <= wptr_q + CNT_W'(1);
              end
              ptr_q   <= ptr_q + CNT_W'(1);
              state_q <= S_READ;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          // Load the result once the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'b0000, CNT_OUT_W'(fill_q), CNT_OUT_W'(inuse_q),
                          CNT_OUT_W'(reaped_q), res_uses_q, res_granted_q, res_failed_q};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench of the keyed slot pool: directed and random command words checked by a slot table.
import kspool_pkg::*;

class slot_pool_scoreboard;
  // Result word, lowest field last
  typedef struct packed {
    logic [3:0]           pad;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [CNT_OUT_W-1:0] inuse_count;
    logic [CNT_OUT_W-1:0] reaped_count;
    logic [USES_W-1:0]    slot_uses;
    logic [IDX_OUT_W-1:0] granted_slot;
    logic                 failed;
  } pool_result_t;

  logic [63:0]          keys[DEF_SLOTS];
  slot_state_e          states[DEF_SLOTS];
  logic [STAMP_W-1:0]   stamps[DEF_SLOTS];
  logic [USES_W-1:0]    uses[DEF_SLOTS];
  int unsigned          fill;
  logic [TIMEOUT_W-1:0] timeout;
  logic [WARM_W-1:0]    warm_floor;
  pool_result_t         expected_results[$];
  int unsigned          errors;

  function new();
    for (int i = 0; i < DEF_SLOTS; i++) begin
      keys[i]   = '0;
      states[i] = ST_FREE;
      stamps[i] = '0;
      uses[i]   = '0;
    end
    fill       = 0;
    timeout    = DEFAULT_TIMEOUT;
    warm_floor = '0;
    errors     = 0;
  endfunction

  function void set_register(logic reg_sel, logic [31:0] value);
    if (reg_sel == REG_TIMEOUT) timeout = value[TIMEOUT_W-1:0];
    else warm_floor = value[WARM_W-1:0];
  endfunction

  // Apply one accepted command word to the table and queue its result
  function void note_command(op_e op, logic [63:0] key, logic [3:0] idx, logic [63:0] now);
    pool_result_t r;
    bit           found;
    int unsigned  i;
    int unsigned  warm;
    int unsigned  busy;
    logic [63:0]  limit;
    r     = '0;
    found = 1'b0;
    case (op)
      OP_ACQUIRE: begin
        // take the lowest idle slot with this key
        for (i = 0; i < fill && !found; i++) begin
          if (states[i] != ST_INUSE && keys[i] == key) begin
            states[i] = ST_INUSE;
            if (uses[i] != '1) uses[i]++;
            r.granted_slot = i[3:0];
            r.slot_uses    = uses[i];
            found          = 1'b1;
          end
        end
        // otherwise append, unless the table is full
        if (!found) begin
          if (fill >= DEF_SLOTS) begin
            r.failed = 1'b1;
          end else begin
            keys[fill]     = key;
            states[fill]   = ST_INUSE;
            uses[fill]     = 1;
            r.granted_slot = fill[3:0];
            r.slot_uses    = 1;
            fill++;
          end
        end
      end
      OP_RELEASE: begin
        if (idx >= fill) begin
          r.failed = 1'b1;
        end else begin
          states[idx] = ST_FREE;
          stamps[idx] = now;
        end
      end
      OP_REAP: begin
        limit = (timeout == 0) ? 64'(DEFAULT_TIMEOUT) : 64'(timeout);
        warm  = 0;
        for (i = 0; i < fill; i++) if (states[i] == ST_WARM) warm++;
        // keep expired slots warm up to the minimum, drop the rest and compact
        i = 0;
        while (i < fill) begin
          if (states[i] == ST_FREE && (now - stamps[i]) > limit) begin
            if (warm >= warm_floor) begin
              for (int j = i; j + 1 < fill; j++) begin
                keys[j]   = keys[j+1];
                states[j] = states[j+1];
                stamps[j] = stamps[j+1];
                uses[j]   = uses[j+1];
              end
              fill--;
              r.reaped_count++;
            end else begin
              states[i] = ST_WARM;
              warm++;
              i++;
            end
          end else begin
            i++;
          end
        end
      end
      default: ;
    endcase
    busy = 0;
    for (i = 0; i < fill; i++) if (states[i] == ST_INUSE) busy++;
    r.inuse_count = busy[4:0];
    r.entry_count = fill[4:0];
    expected_results.push_back(r);
  endfunction

  function void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare one result word with the oldest pending expectation
  function void check_result(logic [OUT_DATA_W-1:0] word);
    pool_result_t want;
    pool_result_t got;
    if (expected_results.size() == 0) begin
      $error("result word with no command pending");
      errors++;
      return;
    end
    want = expected_results.pop_front();
    got  = word;
    check_field("failed", want.failed, got.failed);
    check_field("granted_slot", want.granted_slot, got.granted_slot);
    check_field("slot_uses", want.slot_uses, got.slot_uses);
    check_field("reaped_count", want.reaped_count, got.reaped_count);
    check_field("inuse_count", want.inuse_count, got.inuse_count);
    check_field("entry_count", want.entry_count, got.entry_count);
  endfunction
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          PHASE_WORDS = 170;
  localparam int          KEY_CHOICES = 20;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]       s_axis_tuser  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [2:0]            paddr         = '0;
  logic [31:0]           pwdata        = '0;
  logic [31:0]           prdata;
  logic                  pready;

  slot_pool_scoreboard pool_sb = new();
  int unsigned         words_in    = 0;
  int unsigned         cycle_count = 0;
  bit                  sender_calm = 1'b0;
  bit                  held_off    = 1'b0;
  logic [63:0]         key_pool[KEY_CHOICES];
  logic [63:0]         now_ms;

  keyed_slot_pool_with_idle_reaping dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Check every result word taken by the receiver
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) pool_sb.check_result(m_axis_tdata);
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, one long hold-off once the run is under way
  initial begin
    int unsigned span;
    @(posedge rst_ni);
    forever begin
      if (!held_off && words_in >= 400) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
      repeat (span) @(posedge clk_i);
      span = pick_gap();
      if (span != 0) begin
        m_axis_tready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  // Offer one command word, hold it until taken, then maybe idle
  task automatic send_word(op_e op, logic [63:0] key, logic [3:0] idx, logic [63:0] now);
    int unsigned gap;
    s_axis_tdata  <= {4'b0, now, idx, key};
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pool_sb.note_command(op, key, idx, now);
    words_in++;
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain the block, then write one register over APB
  task automatic write_reg(logic reg_sel, logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pool_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pool_sb.set_register(reg_sel, value);
  endtask

  // Random words with keys from a small pool so slots get reused and reaped
  task automatic run_phase(int words);
    op_e         op;
    logic [63:0] key;
    logic [3:0]  idx;
    logic [63:0] eff;
    int unsigned roll;
    int unsigned step;
    eff = (pool_sb.timeout == 0) ? 64'(DEFAULT_TIMEOUT) : 64'(pool_sb.timeout);
    for (int k = 2; k < KEY_CHOICES; k++) key_pool[k] = {$urandom, $urandom};
    sender_calm = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < words; n++) begin
      // advance time, sometimes past the timeout, rarely anywhere
      step = $urandom_range(0, 99);
      if (step < 90) now_ms += 64'($urandom_range(0, 32'(eff / 3 + 2)));
      else if (step < 98) now_ms += eff + 64'($urandom_range(0, 32'(eff)));
      else now_ms = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_ACQUIRE;
      else if (roll < 75) op = OP_RELEASE;
      else if (roll < 92) op = OP_REAP;
      else if (roll < 96) op = OP_NOP;
      else op = op_e'($urandom_range(0, 3));
      key = (roll < 96) ? key_pool[$urandom_range(0, KEY_CHOICES - 1)] : {$urandom, $urandom};
      if (pool_sb.fill != 0 && $urandom_range(0, 9) != 0)
        idx = 4'($urandom_range(0, pool_sb.fill - 1));
      else
        idx = 4'($urandom_range(0, 15));
      send_word(op, key, idx, now_ms);
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    now_ms      = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: basic acquire and release
    send_word(OP_NOP, '1, 4'hF, '1);
    send_word(OP_RELEASE, '0, 4'd0, 64'd0);       // empty table: bad index
    send_word(OP_ACQUIRE, '0, 4'd0, 64'd0);
    send_word(OP_ACQUIRE, '1, 4'd0, 64'd0);
    send_word(OP_ACQUIRE, '0, 4'd0, 64'd0);       // same key busy: append
    send_word(OP_RELEASE, '0, 4'd1, 64'd100);
    send_word(OP_ACQUIRE, '1, 4'd0, 64'd150);     // reuse, count goes to 2
    send_word(OP_RELEASE, '0, 4'd1, 64'd200);
    send_word(OP_RELEASE, '0, 4'd1, 64'd300);     // already free: restamp
    send_word(OP_RELEASE, '0, 4'd15, 64'd300);    // bad index
    // Directed: idle exactly at the timeout stays, one past it goes
    send_word(OP_REAP, '0, 4'd0, 64'd60300);
    send_word(OP_REAP, '0, 4'd0, 64'd60301);
    // Directed: fill the table, then overflow it
    for (int k = 0; k < 14; k++) send_word(OP_ACQUIRE, 64'h8000_0000_0000_0000 >> k, 4'd0, 64'd0);
    send_word(OP_ACQUIRE, 64'h0123_4567_89AB_CDEF, 4'd0, 64'd0);
    // Directed: idle time across the 64-bit wrap
    send_word(OP_RELEASE, '0, 4'd0, 64'hFFFF_FFFF_FFFF_FFF6);
    send_word(OP_REAP, '0, 4'd0, 64'd59990);
    send_word(OP_REAP, '0, 4'd0, 64'd60000);
    now_ms = 64'd60000;

    // Random phases over several register settings
    run_phase(PHASE_WORDS);
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_WARM_FLOOR, 32'd16);
    run_phase(PHASE_WORDS);
    write_reg(REG_TIMEOUT, 32'd1);
    write_reg(REG_WARM_FLOOR, 32'd2);
    run_phase(PHASE_WORDS);
    write_reg(REG_TIMEOUT, 32'h7FFF_FFFF);
    write_reg(REG_WARM_FLOOR, 32'd0);
    run_phase(PHASE_WORDS);
    write_reg(REG_TIMEOUT, 32'd500);
    write_reg(REG_WARM_FLOOR, 32'd3);
    run_phase(PHASE_WORDS);
    write_reg(REG_TIMEOUT, 32'd200);
    write_reg(REG_WARM_FLOOR, 32'd1);
    run_phase(PHASE_WORDS);

    // Drain, then keep the clock running so that stray words still show up
    s_axis_tvalid <= 1'b0;
    while (pool_sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (pool_sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
